// ===== rtl/core/d2f3_pkg.sv =====
// Shared types and constants for the double to fixed-point decimal text core.
// No dependencies; the core file refers to this package by scoped names.
`default_nettype none

package d2f3_pkg;

    // Biased exponent window that can be formatted (unbiased -11..52)
    localparam logic [10:0] EXP_LO    = 11'd1012;
    localparam logic [10:0] EXP_HI    = 11'd1075;
    // Right shift that turns the mantissa into an integer is EXP_HI - exp
    localparam logic [10:0] EXP_TOP   = 11'd1075;

    // Half-thousandth denominator and the fraction carry step (2000 / 10)
    localparam logic [11:0] HALF_DEN  = 12'd2000;
    localparam logic [11:0] CARRY_STEP = 12'd200;

    // Character codes and register reset
    localparam logic [15:0] CH_MINUS  = 16'h002D;
    localparam logic [15:0] CH_POINT  = 16'h002E;
    localparam logic [15:0] CH_NONE   = 16'h0000;
    localparam logic [15:0] ZERO_CODE_RST = 16'd48;

    // Fraction digits after the point
    localparam logic [4:0]  FRAC_DIGITS = 5'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OOR,
        ST_PREDIV,
        ST_SCALE,
        ST_DIV,
        ST_SIGN,
        ST_ADV,
        ST_DIGIT,
        ST_POINT
    } d2f3_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/d2f3_if.sv =====
// Valid/ready channel interfaces for the input word and the output character.
// Depends on nothing; used by the top level of the text core.
`default_nettype none

interface d2f3_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface d2f3_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        last_char;
    logic        out_of_range;

    modport source (output valid, output char_code, output last_char,
                    output out_of_range, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/double_to_fixed3_decimal_text_core.sv =====
// Double to decimal text core: one binary64 word in, its text with three
// fraction digits out, one character per word. Depends on d2f3_pkg, d2f3_if.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        value_bits[63:0]
//  out_ch    out  valid/ready        char_code[15:0], last_char, out_of_range
//  cfg       in   cfg_we (no wait)   cfg_wdata[15:0] = zero digit code
//
// One shared compare/subtract unit runs under a sequencer: a constant table
// gives the scale over 2000 at accept, then the mantissa is added, the base
// grows by one decade per step (up to 15 decades), the leading digit is found
// by repeated subtraction, and each further digit takes a carry step, repeated
// subtraction with a closing compare, and an output step.
// in_ch.ready is high only in idle. rst_n clears the sequencer and sets the
// zero code to 48. A stalled out_ch holds the sequencer in its output states.
`default_nettype none

module double_to_fixed3_decimal_text_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    d2f3_in_if.sink          in_ch,
    d2f3_out_if.source       out_ch
);

    d2f3_pkg::d2f3_state_t state_reg, state_next;

    logic [15:0] zero_reg;
    logic        neg_reg, neg_next;
    logic [52:0] mant_reg, mant_next;
    logic [63:0] base_reg, base_next;
    logic [67:0] num_reg, num_next;
    logic [10:0] mn_reg, mn_next;
    logic [3:0]  q_reg, q_next;
    logic [3:0]  d_reg, d_next;
    logic [3:0]  dg_reg, dg_next;
    logic [4:0]  k_reg, k_next;
    logic [4:0]  scale_reg, scale_next;
    logic        first_reg, first_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] char_reg, char_next;
    logic        last_reg, last_next;
    logic        oor_reg, oor_next;

    logic        in_acc;
    logic        slot_free;
    logic [10:0] exp_f;
    logic [5:0]  shift_w;
    logic [63:0] pre_q;
    logic [10:0] pre_r;
    logic [67:0] base_ext;
    logic [67:0] base10;
    logic [3:0]  carry_t;
    logic [14:0] mn10;
    logic        is_last;
    logic [3:0]  d_out;

    assign in_ch.ready      = (state_reg == d2f3_pkg::ST_IDLE);
    assign in_acc           = in_ch.valid && in_ch.ready;
    assign slot_free        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.char_code = char_reg;
    assign out_ch.last_char = last_reg;
    assign out_ch.out_of_range = oor_reg;

    // Decode the exponent and the shared datapath terms
    assign exp_f    = in_ch.value_bits[62:52];
    assign shift_w  = 6'(d2f3_pkg::EXP_TOP - exp_f);
    assign base_ext = {4'b0, base_reg};
    assign base10   = (base_ext << 3) + (base_ext << 1);
    assign mn10     = ({4'b0, mn_reg} << 3) + ({4'b0, mn_reg} << 1);
    assign is_last  = (k_reg == scale_reg + d2f3_pkg::FRAC_DIGITS);
    // Lower an odd last digit on an exact tie
    assign d_out    = (is_last && q_reg == 4'd0 && num_reg == 68'd0 && d_reg[0])
                      ? d_reg - 4'd1 : d_reg;

    // Look up scale / 2000 and scale % 2000 for the decoded shift
    always_comb
    begin
        pre_q = 64'd0;
        pre_r = 11'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (shift_w == 6'(i))
            begin
                pre_q = (64'd1 << i) / 64'(d2f3_pkg::HALF_DEN);
                pre_r = 11'((64'd1 << i) % 64'(d2f3_pkg::HALF_DEN));
            end
        end
    end

    // Carry digit out of the fraction remainder: floor(10 * mn / 2000)
    always_comb
    begin
        carry_t = 4'd0;
        for (int i = 1; i <= 9; i++)
        begin
            if ({1'b0, mn_reg} >= d2f3_pkg::CARRY_STEP * 12'(i))
                carry_t = carry_t + 4'd1;
        end
    end

    // Sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mant_next      = mant_reg;
        base_next      = base_reg;
        num_next       = num_reg;
        mn_next        = mn_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        dg_next        = dg_reg;
        k_next         = k_reg;
        scale_next     = scale_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        oor_next       = oor_reg;

        case (state_reg)
            d2f3_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    neg_next   = in_ch.value_bits[63];
                    mant_next  = {1'b1, in_ch.value_bits[51:0]};
                    base_next  = 64'd1 << shift_w;
                    num_next   = {4'b0, pre_q};
                    mn_next    = pre_r;
                    scale_next = 5'd0;
                    k_next     = 5'd0;
                    first_next = 1'b1;
                    if (exp_f < d2f3_pkg::EXP_LO || exp_f > d2f3_pkg::EXP_HI)
                        state_next = d2f3_pkg::ST_OOR;
                    else
                        state_next = d2f3_pkg::ST_PREDIV;
                end
            end
            d2f3_pkg::ST_OOR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = d2f3_pkg::CH_NONE;
                    last_next      = 1'b1;
                    oor_next       = 1'b1;
                    state_next     = d2f3_pkg::ST_IDLE;
                end
            end
            // Add the mantissa to the half-thousandth increment
            d2f3_pkg::ST_PREDIV:
            begin
                num_next   = num_reg + {15'b0, mant_reg};
                state_next = d2f3_pkg::ST_SCALE;
            end
            // Grow the base by ten until the integer part is one digit
            d2f3_pkg::ST_SCALE:
            begin
                if (num_reg >= base10)
                begin
                    base_next  = base10[63:0];
                    scale_next = scale_reg + 5'd1;
                end
                else
                begin
                    q_next     = 4'd0;
                    state_next = d2f3_pkg::ST_DIV;
                end
            end
            // Subtract the base until below it: quotient digit in q
            d2f3_pkg::ST_DIV:
            begin
                if (num_reg >= base_ext)
                begin
                    num_next = num_reg - base_ext;
                    q_next   = q_reg + 4'd1;
                end
                else if (first_reg)
                begin
                    dg_next    = q_reg;
                    first_next = 1'b0;
                    state_next = d2f3_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = d2f3_pkg::ST_DIGIT;
                end
            end
            d2f3_pkg::ST_SIGN:
            begin
                if (!neg_reg)
                    state_next = d2f3_pkg::ST_ADV;
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = d2f3_pkg::CH_MINUS;
                    last_next      = 1'b0;
                    oor_next       = 1'b0;
                    state_next     = d2f3_pkg::ST_ADV;
                end
            end
            // Advance: next numerator is 10 * remainder plus the carry digit
            d2f3_pkg::ST_ADV:
            begin
                d_next     = dg_reg;
                num_next   = (num_reg << 3) + (num_reg << 1) + {64'b0, carry_t};
                mn_next    = 11'(mn10 - 15'(carry_t) * 15'(d2f3_pkg::HALF_DEN));
                q_next     = 4'd0;
                state_next = d2f3_pkg::ST_DIV;
            end
            d2f3_pkg::ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = zero_reg + {12'b0, d_out};
                    last_next      = is_last;
                    oor_next       = 1'b0;
                    dg_next        = q_reg;
                    if (k_reg == scale_reg)
                        state_next = d2f3_pkg::ST_POINT;
                    else if (is_last)
                        state_next = d2f3_pkg::ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + 5'd1;
                        state_next = d2f3_pkg::ST_ADV;
                    end
                end
            end
            d2f3_pkg::ST_POINT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = d2f3_pkg::CH_POINT;
                    last_next      = 1'b0;
                    oor_next       = 1'b0;
                    k_next         = k_reg + 5'd1;
                    state_next     = d2f3_pkg::ST_ADV;
                end
            end
            default:
            begin
                state_next = d2f3_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= d2f3_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            zero_reg      <= d2f3_pkg::ZERO_CODE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                zero_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mant_reg  <= mant_next;
        base_reg  <= base_next;
        num_reg   <= num_next;
        mn_reg    <= mn_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        dg_reg    <= dg_next;
        k_reg     <= k_next;
        scale_reg <= scale_next;
        first_reg <= first_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        oor_reg   <= oor_next;
    end

    // A quotient digit never passes nine
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d2f3_pkg::ST_DIGIT) |-> (q_reg <= 4'd9))
        else $error("quotient digit above nine");

    // The remainder is below the base when a digit goes out
    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d2f3_pkg::ST_DIGIT) |-> (num_reg < base_ext))
        else $error("remainder not below base");

    // The fraction remainder stays below 2000
    a_carry_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d2f3_pkg::ST_ADV) |-> ({1'b0, mn_reg} < d2f3_pkg::HALF_DEN))
        else $error("fraction carry out of range");

    // An accepted word leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != d2f3_pkg::ST_IDLE))
        else $error("sequencer idle after accept");

endmodule

`default_nettype wire
